[hdl/chromatogram_grid_resampler_assert.svh]
// assertion macros for the grid resampler checker
`ifndef CHROMATOGRAM_GRID_RESAMPLER_ASSERT_SVH
`define CHROMATOGRAM_GRID_RESAMPLER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define CGR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define CGR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also watches the reset itself
`define CGR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/cgr_pkg.sv]
package cgr_pkg;

  localparam int DIV_REM_W = 42;
  localparam int DIV_BIT_W = 41;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] REG_START_POSITION = 2'd0;
  localparam logic [1:0] REG_CELL_WIDTH     = 2'd1;
  localparam logic [1:0] REG_LAST_CELL      = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_IDX,
    ST_IDX_WAIT,
    ST_PLACE,
    ST_MAX_RD,
    ST_MAX_WR,
    ST_INT_MUL,
    ST_INT_SPAN,
    ST_INT_LO,
    ST_INT_HI,
    ST_INT_DIV,
    ST_INT_WAIT,
    ST_READ,
    ST_READ_Q,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_BIT_W-1:0] bits;
    logic [DIV_CNT_W-1:0] iters;
    logic [DIV_BIT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_BIT_W-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/cgr_div.sv]
module cgr_div (
  input  logic              clk,
  input  logic              rst,
  input  cgr_pkg::div_req_t req,
  output cgr_pkg::div_rsp_t rsp
);
  import cgr_pkg::*;

  logic [DIV_REM_W-1:0] rem;
  logic [DIV_BIT_W-1:0] sh;
  logic [DIV_BIT_W-1:0] q;
  logic [DIV_BIT_W-1:0] dv;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_REM_W-1:0] r2;
  logic                 ge;

  // one quotient bit per cycle, restoring; divisor held from the start request
  always_comb begin
    r2 = {rem[DIV_REM_W-2:0], sh[DIV_BIT_W-1]};
    ge = (r2 >= {1'b0, dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      sh  <= req.bits;
      q   <= '0;
      dv  <= req.divisor;
      cnt <= req.iters;
    end else if (busy) begin
      rem <= ge ? (r2 - {1'b0, dv}) : r2;
      sh  <= {sh[DIV_BIT_W-2:0], 1'b0};
      q   <= {q[DIV_BIT_W-2:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;

endmodule

[hdl/chromatogram_grid_resampler.sv]
// one item at a time; a sample runs the 41-step index division (skipped for a negative
// numerator) and one 33-step division per interpolated cell in the shared bit-serial
// divider; grid store is a 1-port-read RAM
// reset is synchronous; after reset a clearing pass zeroes the grid store,
// sample_ready stays low during it, configuration writes are taken always
module chromatogram_grid_resampler #(
  parameter int GRID_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic [1:0]  func,
  input  logic [31:0] time_minutes,
  input  logic [31:0] intensity,
  input  logic [11:0] cell_index,
  // result item channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] cell_value,
  output logic        was_clamped,
  // configuration port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cgr_pkg::*;

  localparam int AW   = $clog2(GRID_DEPTH);
  localparam int JWW  = AW + 31;                      // width of j * cell_width
  localparam int NW   = ((JWW + 2 > 39) ? JWW + 2 : 39) + 1;  // span numerator width
  localparam logic [31:0] LAST_IDX = 32'(GRID_DEPTH - 1);

  // configuration registers
  logic signed [31:0] start_position;
  logic [30:0]        cell_width;
  logic [11:0]        last_cell;

  // control
  state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic          clr_emit;

  // item registers
  logic [1:0]         func_r;
  logic [37:0]        x_r;
  logic signed [31:0] y_r;
  logic [11:0]        ci_r;
  logic [AW-1:0]      idx;
  logic [AW:0]        j;
  logic [31:0]        res_value;
  logic               res_clamped;

  // sample history
  logic [AW-1:0]      prev_cell;
  logic [37:0]        prev_time;
  logic signed [31:0] prev_int;
  logic               seen_first;

  // interpolation datapath
  logic signed [38:0] dd;
  logic [37:0]        dabs;
  logic [32:0]        babs;
  logic               dyneg;
  logic [JWW-1:0]     jw;
  logic [37:0]        a_r;
  logic               neg_r;
  logic [70:0]        prod;

  // grid store
  logic [31:0]   mem [GRID_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // derived values
  logic [30:0]        weff;
  logic [31:0]        lim_ext;
  logic [AW-1:0]      limit;
  logic signed [40:0] nidx;
  logic [AW-1:0]      idx_q;
  logic               idx_clamp;
  logic               same;
  logic [AW:0]        j_first;
  logic [AW:0]        j_inc;
  logic signed [NW-1:0] nspan;
  logic signed [NW-1:0] d_ext;
  logic signed [NW-1:0] ncl;
  logic [NW-1:0]      nmag;
  logic [18:0]        mul_a;
  logic [51:0]        pp;
  logic [71:0]        dvd;
  logic signed [33:0] ival;
  logic               in_acc;
  logic               read_ok;

  cgr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_acc  = sample_valid && sample_ready;
  assign weff    = (cell_width == 31'd0) ? 31'd1 : cell_width;  // zero width acts as one
  assign lim_ext = ({20'd0, last_cell} > LAST_IDX) ? LAST_IDX : {20'd0, last_cell};
  assign limit   = lim_ext[AW-1:0];
  assign read_ok = ({20'd0, ci_r} <= LAST_IDX);

  // 2*(x - start) + w; the quotient by 2w rounds half up
  assign nidx = ($signed({3'd0, x_r}) - $signed({{9{start_position[31]}}, start_position}))
                * 41'sd2 + $signed({10'd0, weff});

  always_comb begin
    idx_q     = div_rsp.quot[AW-1:0];
    idx_clamp = 1'b0;
    if (div_rsp.quot > {{(41-AW){1'b0}}, limit}) begin
      idx_q     = limit;
      idx_clamp = 1'b1;
    end
  end

  assign same    = !seen_first || (idx == prev_cell);
  assign j_first = {1'b0, prev_cell} + (AW+1)'(1);
  assign j_inc   = j + (AW+1)'(1);

  // span position of cell j relative to the previous point, saturated into the segment
  always_comb begin
    nspan = $signed({{(NW-32){start_position[31]}}, start_position})
          + $signed({{(NW-JWW){1'b0}}, jw})
          - $signed({{(NW-38){1'b0}}, prev_time});
    d_ext = $signed({{(NW-39){dd[38]}}, dd});
    ncl   = nspan;
    if (!dd[38]) begin
      if (nspan < 0)     ncl = '0;
      if (nspan > d_ext) ncl = d_ext;
    end else begin
      if (nspan > 0)     ncl = '0;
      if (nspan < d_ext) ncl = d_ext;
    end
    nmag = ncl[NW-1] ? NW'(-ncl) : NW'(ncl);
  end

  // one narrow multiplier, two partial products
  assign mul_a = (state == ST_INT_HI) ? a_r[37:19] : a_r[18:0];
  assign pp    = {33'd0, mul_a} * {19'd0, babs};
  assign dvd   = {prod, 1'b0} + {34'd0, dabs};
  assign ival  = $signed({{2{prev_int[31]}}, prev_int})
               + (neg_r ? -$signed({1'b0, div_rsp.quot[32:0]})
                        :  $signed({1'b0, div_rsp.quot[32:0]}));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= -32'sd3440640;
      cell_width     <= 31'd163840;
      last_cell      <= 12'd4095;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_POSITION: start_position <= cfg_data;
        REG_CELL_WIDTH:     cell_width     <= cfg_data[30:0];
        REG_LAST_CELL:      last_cell      <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (clr_addr == AW'(GRID_DEPTH - 1)) state_next = clr_emit ? ST_FINISH
                                                                              : ST_IDLE;
      ST_IDLE: begin
        if (sample_valid) begin
          case (func)
            FUNC_SAMPLE: state_next = ST_IDX;
            FUNC_READ:   state_next = ST_READ;
            FUNC_CLEAR:  state_next = ST_CLEAR;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_IDX:      state_next = nidx[40] ? ST_PLACE : ST_IDX_WAIT;
      ST_IDX_WAIT: if (div_rsp.done) state_next = ST_PLACE;
      ST_PLACE: begin
        if (same)                  state_next = ST_MAX_RD;
        else if (j_first < {1'b0, idx}) state_next = ST_INT_MUL;
        else                       state_next = ST_FINISH;
      end
      ST_MAX_RD:   state_next = ST_MAX_WR;
      ST_MAX_WR:   state_next = ST_FINISH;
      ST_INT_MUL:  state_next = ST_INT_SPAN;
      ST_INT_SPAN: begin
        if (dd != 39'sd0)             state_next = ST_INT_LO;
        else if (j_inc < {1'b0, idx}) state_next = ST_INT_MUL;
        else                          state_next = ST_FINISH;
      end
      ST_INT_LO:   state_next = ST_INT_HI;
      ST_INT_HI:   state_next = ST_INT_DIV;
      ST_INT_DIV:  state_next = ST_INT_WAIT;
      ST_INT_WAIT: begin
        if (div_rsp.done) state_next = (j_inc < {1'b0, idx}) ? ST_INT_MUL : ST_FINISH;
      end
      ST_READ:     state_next = ST_READ_Q;
      ST_READ_Q:   state_next = ST_FINISH;
      ST_FINISH:   if (!result_valid || result_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: memory port and divider requests
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = y_r;
    mem_raddr    = idx;
    sample_ready = (state == ST_IDLE);
    div_req      = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDX: begin
        // index division: 41 quotient bits of the non-negative numerator
        div_req.start   = !nidx[40];
        div_req.bits    = nidx[40:0];
        div_req.iters   = DIV_CNT_W'(41);
        div_req.divisor = {9'd0, weff, 1'b0};
      end
      ST_PLACE:    mem_we = !same;
      ST_MAX_WR:   mem_we = (y_r > $signed(mem_q));
      ST_INT_SPAN: begin
        // zero time step: skipped cells take the new intensity
        mem_we    = (dd == 39'sd0);
        mem_waddr = j[AW-1:0];
      end
      ST_INT_DIV: begin
        // quotient is known to fit in 33 bits, so the top part preloads the remainder
        div_req.start    = 1'b1;
        div_req.rem_init = {3'd0, dvd[71:33]};
        div_req.bits     = {dvd[32:0], 8'd0};
        div_req.iters    = DIV_CNT_W'(33);
        div_req.divisor  = {2'd0, dabs, 1'b0};
      end
      ST_INT_WAIT: begin
        mem_we    = div_rsp.done;
        mem_waddr = j[AW-1:0];
        mem_wdata = ival[31:0];
      end
      ST_READ:     mem_raddr = AW'(ci_r);
      default: ;
    endcase
  end

  // grid store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      clr_emit     <= 1'b0;
      seen_first   <= 1'b0;
      prev_cell    <= '0;
      prev_time    <= '0;
      prev_int     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        if (clr_addr == AW'(GRID_DEPTH - 1)) begin
          seen_first <= 1'b0;
          clr_addr   <= '0;
        end else begin
          clr_addr <= clr_addr + AW'(1);
        end
      end
      if (in_acc) clr_emit <= (func == FUNC_CLEAR);
      // history moves on once the sample's cells are written
      if (state == ST_FINISH && state_next == ST_IDLE && func_r == FUNC_SAMPLE &&
          !clr_emit) begin
        prev_cell  <= idx;
        prev_time  <= x_r;
        prev_int   <= y_r;
        seen_first <= 1'b1;
      end
      if (state == ST_FINISH && state_next == ST_IDLE) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r      <= func;
      x_r         <= {time_minutes, 6'd0} - {4'd0, time_minutes, 2'd0};  // minutes * 60
      y_r         <= intensity;
      ci_r        <= cell_index;
      res_value   <= '0;
      res_clamped <= 1'b0;
    end
    if (state == ST_FINISH && state_next == ST_IDLE) begin
      cell_value  <= res_value;
      was_clamped <= res_clamped;
    end
    case (state)
      ST_IDX: begin
        if (nidx[40]) begin
          idx         <= '0;
          res_clamped <= 1'b1;
        end
      end
      ST_IDX_WAIT: begin
        if (div_rsp.done) begin
          idx         <= idx_q;
          res_clamped <= idx_clamp;
        end
      end
      ST_PLACE: begin
        j     <= j_first;
        dd    <= $signed({1'b0, x_r}) - $signed({1'b0, prev_time});
        dabs  <= (x_r >= prev_time) ? (x_r - prev_time) : (prev_time - x_r);
        babs  <= (y_r >= prev_int) ? 33'($signed({y_r[31], y_r}) - $signed({prev_int[31], prev_int}))
                                   : 33'($signed({prev_int[31], prev_int}) - $signed({y_r[31], y_r}));
        dyneg <= (y_r < prev_int);
      end
      ST_INT_MUL:  jw <= JWW'(j[AW-1:0]) * JWW'(weff);
      ST_INT_SPAN: begin
        a_r   <= nmag[37:0];
        neg_r <= ((ncl < 0) != dyneg) != dd[38];
        if (dd == 39'sd0) j <= j_inc;
      end
      ST_INT_LO:   prod <= {19'd0, pp};
      ST_INT_HI:   prod <= prod + {pp, 19'd0};
      ST_INT_WAIT: if (div_rsp.done) j <= j_inc;
      ST_READ_Q:   res_value <= read_ok ? mem_q : 32'd0;
      default: ;
    endcase
  end

endmodule

[hdl/cgr_checker.sv]
`include "chromatogram_grid_resampler_assert.svh"

module cgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic [1:0]  func,
  input logic [31:0] time_minutes,
  input logic [31:0] intensity,
  input logic [11:0] cell_index,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] cell_value,
  input logic        was_clamped,
  input logic        cfg_write,
  input logic [1:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // a stalled result item holds
  `CGR_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(cell_value) && $stable(was_clamped), "result item changed while stalled")

  // a clamped index only comes from a sample, which reads back zero
  `CGR_ASSERT_IMP(a_clamp_zero, clk, rst, result_valid && was_clamped, cell_value == 32'd0, "clamped result with nonzero value")

  // one item in work at a time
  `CGR_ASSERT_NEXT(a_one_item, clk, rst, sample_valid && sample_ready, !sample_ready, "ready right after an accepted item")

  // reset starts the clearing pass with nothing to deliver
  `CGR_ASSERT_ALWAYS(a_reset_quiet, clk, rst, !result_valid && !sample_ready, "block not quiet after reset")

endmodule

bind chromatogram_grid_resampler cgr_checker u_cgr_checker (.*);

[tb/chromatogram_grid_resampler_tb.sv]
module chromatogram_grid_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cgr_pkg::*;

  localparam int DEPTH = 4096;
  // func code that the block leaves unused
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic        clk;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  logic [1:0]  func;
  logic [31:0] time_minutes;
  logic [31:0] intensity;
  logic [11:0] cell_index;
  logic        result_valid;
  logic        result_ready;
  logic [31:0] cell_value;
  logic        was_clamped;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  chromatogram_grid_resampler #(.GRID_DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .func(func),
    .time_minutes(time_minutes),
    .intensity(intensity),
    .cell_index(cell_index),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .cell_value(cell_value),
    .was_clamped(was_clamped),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // one expected result item
  typedef struct {
    logic [31:0] value;
    logic        clamped;
  } grid_result_t;

  // directed rows: typed result used only when known is set
  typedef struct {
    logic [1:0]  fn;
    logic [31:0] t;
    logic [31:0] y;
    logic [11:0] ci;
    bit          known;
    logic [31:0] value;
    logic        clamped;
  } grid_row_t;

  grid_result_t pending_results[$];
  int           fail_count;
  int           results_seen;
  int           sender_idle_pct;
  int           receiver_stall_pct;

  // shadow copy of the block state and registers
  int          shadow_grid[DEPTH];
  int unsigned shadow_prev_cell;
  longint      shadow_prev_time;
  int          shadow_prev_y;
  bit          shadow_seen;
  longint      shadow_start;
  longint      shadow_width;
  int unsigned shadow_last;

  // stimulus bookkeeping
  longint      walk_time;
  int          n_samples;
  int          n_reads;
  int          n_clamps;
  int          n_clears;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest correct run
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint width_in_use();
    return (shadow_width == 0) ? 64'sd1 : shadow_width;
  endfunction

  // linear interpolation at cell j, rounded to nearest, ties away from the previous point
  function automatic int interp_cell(int unsigned j, longint x, int y);
    longint      tx;
    longint      d;
    longint      n;
    longint      dy;
    logic [127:0] an;
    logic [127:0] ady;
    logic [127:0] ad;
    logic [127:0] q;
    bit          neg;
    tx = shadow_start + longint'(j) * width_in_use();
    d  = x - shadow_prev_time;
    n  = tx - shadow_prev_time;
    dy = longint'(y) - longint'(shadow_prev_y);
    if (d == 0) return y;
    // fraction saturated to [0,1] when the registers moved under the segment
    if (d > 0) begin
      if (n < 0) n = 0;
      if (n > d) n = d;
    end else begin
      if (n > 0) n = 0;
      if (n < d) n = d;
    end
    neg = ((n < 0) != (dy < 0)) != (d < 0);
    an  = (n < 0) ? -n : n;
    ady = (dy < 0) ? -dy : dy;
    ad  = (d < 0) ? -d : d;
    q   = ((an * ady) * 2 + ad) / (ad * 2);
    return int'(longint'(shadow_prev_y) + (neg ? -longint'(q[63:0]) : longint'(q[63:0])));
  endfunction

  // advance the shadow state by one item and return what the block should answer
  function automatic grid_result_t resample_item(logic [1:0] fn, logic [31:0] t,
                                                 logic [31:0] y, logic [11:0] ci);
    grid_result_t r;
    longint       x;
    longint       num;
    longint       q;
    longint       w;
    int unsigned  limit;
    int unsigned  idx;
    r.value   = '0;
    r.clamped = 1'b0;
    case (fn)
      FUNC_SAMPLE: begin
        x     = longint'(t) * 60;
        w     = width_in_use();
        limit = (shadow_last > DEPTH - 1) ? DEPTH - 1 : shadow_last;
        num   = 2 * (x - shadow_start) + w;
        if (num < 0) begin
          idx = 0;
          r.clamped = 1'b1;
        end else begin
          q = num / (2 * w);
          if (q > longint'(limit)) begin
            idx = limit;
            r.clamped = 1'b1;
          end else begin
            idx = int'(q);
          end
        end
        if (!shadow_seen || idx == shadow_prev_cell) begin
          if ($signed(y) > shadow_grid[idx]) shadow_grid[idx] = $signed(y);
        end else begin
          shadow_grid[idx] = $signed(y);
          for (int unsigned j = shadow_prev_cell + 1; j < idx; j++)
            shadow_grid[j] = interp_cell(j, x, $signed(y));
        end
        shadow_prev_cell = idx;
        shadow_prev_time = x;
        shadow_prev_y    = $signed(y);
        shadow_seen      = 1'b1;
      end
      FUNC_READ: begin
        if (ci < DEPTH) r.value = shadow_grid[ci];
      end
      FUNC_CLEAR: begin
        foreach (shadow_grid[k]) shadow_grid[k] = 0;
        shadow_seen = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one item; valid stays high into the next item unless a gap is drawn
  task automatic send_item(logic [1:0] fn, logic [31:0] t, logic [31:0] y,
                           logic [11:0] ci, bit known, grid_result_t typed);
    grid_result_t r;
    if ($urandom_range(99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    func         <= fn;
    time_minutes <= t;
    intensity    <= y;
    cell_index   <= ci;
    do @(posedge clk); while (!sample_ready);
    r = resample_item(fn, t, y, ci);
    if (known) r = typed;
    pending_results.push_back(r);
    if (fn == FUNC_SAMPLE) begin
      n_samples++;
      if (r.clamped) n_clamps++;
    end
    if (fn == FUNC_READ) n_reads++;
    if (fn == FUNC_CLEAR) n_clears++;
  endtask

  // wait for the block to drain, then write one register
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_START_POSITION: shadow_start = longint'($signed(data));
      REG_CELL_WIDTH:     shadow_width = longint'(data & 32'h7FFF_FFFF);
      REG_LAST_CELL:      shadow_last  = data & 32'hFFF;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [31:0] start, logic [31:0] width, logic [31:0] last);
    write_reg(REG_START_POSITION, start);
    write_reg(REG_CELL_WIDTH, width);
    write_reg(REG_LAST_CELL, last);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // compare every accepted result item with the oldest expectation
  always @(posedge clk) begin
    grid_result_t e;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: cell_value %0h", cell_value);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (cell_value !== e.value) begin
          $error("cell_value expected %0h got %0h", e.value, cell_value);
          fail_count++;
        end
        if (was_clamped !== e.clamped) begin
          $error("was_clamped expected %0b got %0b", e.clamped, was_clamped);
          fail_count++;
        end
      end
    end
  end

  // directed rows, run straight after reset with the reset grid
  grid_row_t directed_rows[] = '{
    // empty store reads zero at both ends
    '{FUNC_READ,   32'h0,         32'h0,         12'd0,    1, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd4095, 1, 32'h0,         1'b0},
    // first sample lands in cell 21, largest intensity
    '{FUNC_SAMPLE, 32'h0,         32'h7FFF_FFFF, 12'd0,    1, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd21,   1, 32'h7FFF_FFFF, 1'b0},
    // same cell again keeps the larger value
    '{FUNC_SAMPLE, 32'h0,         32'h8000_0000, 12'd0,    1, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd21,   1, 32'h7FFF_FFFF, 1'b0},
    // one minute on: cell 45, cells between interpolated
    '{FUNC_SAMPLE, 32'h0001_0000, 32'd100,       12'd0,    0, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd30,   0, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd44,   0, 32'h0,         1'b0},
    // latest possible time clamps to the last cell
    '{FUNC_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0,    1, 32'h0,         1'b1},
    '{FUNC_READ,   32'h0,         32'h0,         12'd4095, 1, 32'hFFFF_FFFF, 1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd2000, 0, 32'h0,         1'b0},
    // unused func returns zeros and touches nothing
    '{FUNC_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF,  1, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd45,   1, 32'd100,       1'b0},
    // clear empties the store and restarts the first-sample rule
    '{FUNC_CLEAR,  32'h0,         32'h0,         12'd0,    1, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd4095, 1, 32'h0,         1'b0},
    '{FUNC_SAMPLE, 32'h0,         32'd5,         12'd0,    1, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd21,   1, 32'd5,         1'b0},
    '{FUNC_SAMPLE, 32'h0000_8000, 32'h8000_0000, 12'd0,    0, 32'h0,         1'b0},
    '{FUNC_READ,   32'h0,         32'h0,         12'd22,   0, 32'h0,         1'b0}
  };

  // one random item; samples mostly walk forward a few cells at a time
  task automatic random_item(bit wild);
    int           pick;
    longint       step;
    longint       span;
    logic [31:0]  t;
    logic [11:0]  ci;
    grid_result_t none;
    none = '{default: '0};
    pick = $urandom_range(99);
    if (pick < 2) begin
      send_item(FUNC_CLEAR, $urandom, $urandom, 12'($urandom), 0, none);
    end else if (pick < 4) begin
      send_item(FUNC_NONE, $urandom, $urandom, 12'($urandom), 0, none);
    end else if (pick < 30) begin
      if ($urandom_range(3) == 0) ci = 12'($urandom);
      else ci = 12'(shadow_prev_cell + $urandom_range(0, 6) - 5);
      send_item(FUNC_READ, $urandom, $urandom, ci, 0, none);
    end else begin
      if (wild && $urandom_range(99) < 20) begin
        t = $urandom;
        walk_time = longint'(t);
      end else begin
        // a cell spans width/60 of a minute; step up to about three cells
        span = width_in_use() / 20;
        if (span < 1) span = 1;
        if (span > 64'sd4194304) span = 64'sd4194304;
        step = longint'($urandom_range(0, int'(span)));
        if ($urandom_range(99) < 15) walk_time -= step;
        else walk_time += step;
        if (walk_time < 0) walk_time = 0;
        if (walk_time > 64'sd4294967295) walk_time = 64'sd4294967295;
        t = walk_time[31:0];
      end
      send_item(FUNC_SAMPLE, t, $urandom, 12'($urandom), 0, none);
    end
  endtask

  // a random phase under one grid setting, cycling through the idling modes
  task automatic random_phase(int count, bit wild);
    longint mid;
    // aim the walk somewhere inside the grid
    mid = (shadow_start + width_in_use() * longint'(shadow_last / 2)) / 60;
    if (mid < 0) mid = 0;
    if (mid > 64'sd4294967295) mid = 64'sd4294967295;
    walk_time = mid;
    for (int i = 0; i < count; i++) begin
      case ((i / 64) % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      random_item(wild);
    end
  endtask

  initial begin
    grid_result_t typed;
    logic [31:0]  rnd_width;
    rst                = 1'b1;
    sample_valid       = 1'b0;
    func               = FUNC_SAMPLE;
    time_minutes       = '0;
    intensity          = '0;
    cell_index         = '0;
    cfg_write          = 1'b0;
    cfg_index          = REG_START_POSITION;
    cfg_data           = '0;
    fail_count         = 0;
    results_seen       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    n_samples          = 0;
    n_reads            = 0;
    n_clamps           = 0;
    n_clears           = 0;
    foreach (shadow_grid[k]) shadow_grid[k] = 0;
    shadow_prev_cell = 0;
    shadow_prev_time = 0;
    shadow_prev_y    = 0;
    shadow_seen      = 1'b0;
    shadow_start     = -64'sd3440640;
    shadow_width     = 64'sd163840;
    shadow_last      = 4095;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset registers
    foreach (directed_rows[i]) begin
      typed.value   = directed_rows[i].value;
      typed.clamped = directed_rows[i].clamped;
      send_item(directed_rows[i].fn, directed_rows[i].t, directed_rows[i].y,
                directed_rows[i].ci, directed_rows[i].known, typed);
    end

    // reset registers, ordinary walk
    random_phase(260, 1'b0);
    // zero width behaves as one, tiny grid so the walk clamps
    set_grid(32'h0, 32'h0, 32'd31);
    random_phase(250, 1'b1);
    // largest start and width, full grid
    set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd4095);
    random_phase(250, 1'b1);
    // most negative start, single usable cell
    set_grid(32'h8000_0000, 32'h0001_0000, 32'd0);
    random_phase(250, 1'b1);
    // random setting; top data bit of the width is dropped by the block
    rnd_width = {1'($urandom_range(1)), 11'd0, 20'($urandom_range(20'h1000, 20'hFFFFF))};
    set_grid($urandom, rnd_width, 32'd200);
    random_phase(250, 1'b1);
    // back to the reset grid without a clear, so the first segment spans a change
    set_grid(32'hFFCB_8000, 32'd163840, 32'd4095);
    random_phase(270, 1'b0);

    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d samples (%0d clamped), %0d reads, %0d clears, %0d results",
             n_samples, n_clamps, n_reads, n_clears, results_seen);
    $display("over six grid settings with stalls on both channels");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
